@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL that checks itself.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clock edge outside reset (active-low reset).
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cond at one edge implies res at the same edge.
`define CHK_IMPLY(label, clk, rst_n, cond, res, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (res)) \
    else $error(msg);

`endif

@@ sv/sltb_pkg.sv @@
// Shared types and codes for the sorted list table.
// No dependencies; used by sltb_cell and sorted_list_table_top.
package sltb_pkg;

  localparam logic [2:0] OP_INSERT     = 3'd0;
  localparam logic [2:0] OP_FIND       = 3'd1;
  localparam logic [2:0] OP_READ       = 3'd2;
  localparam logic [2:0] OP_DEL_FIRST  = 3'd3;
  localparam logic [2:0] OP_DEL_ALL    = 3'd4;

  localparam logic [1:0] ST_DONE       = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
  localparam logic [1:0] ST_FULL       = 2'd2;

  localparam int OP_W   = 3;
  localparam int ST_W   = 2;
  localparam int POS_W  = 7;
  localparam int FLD_W  = 32;

  // Strobes from the sequencer to every cell.
  typedef struct packed {
    logic cmp;   // capture compare flags against the key
    logic ins;   // open a slot and insert the key
    logic del;   // close up over the first match
  } ctl_t;

  // Compare flags held by one cell.
  typedef struct packed {
    logic valid; // cell lies below the entry count
    logic gt;    // stored value greater than key
    logic eq;    // stored value equal to key
    logic sel;   // cell sits at the requested read position
  } flags_t;

endpackage

@@ sv/sorted_list_table_top.sv @@
// Sorted list table: a chain of value cells driven by a small sequencer.
// Depends on sltb_pkg, sltb_cell and assert_macros.svh.
//
//  port group  dir  tdata fields (low bit up)                       tuser
//  in_*        in   item_value[31:0], position[38:32], pad to 40    operation[2:0]
//  out_*       out  read_value[31:0], removed_count[38:32],         status[1:0]
//                   entry_count[45:39], pad to 48
//
// Insert, find, read and delete-first pass through the accept state, a compare
// state in which every cell compares against the key, and an apply state; the
// result is registered when the apply step completes.
// Delete-all repeats the compare and apply states until a compare finds no
// match; the chain closes up over one match per compare/apply pair.
// Reset clears the state, entry count, removal count and result valid; cell contents need no clearing.
// A waiting result blocks only the apply step; the next item is accepted.
`include "assert_macros.svh"

module sorted_list_table_top #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // item_value[31:0], position[38:32]
  input  logic [2:0]  in_tuser,   // operation[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // read_value[31:0], removed_count[38:32], entry_count[45:39]
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int FW    = sltb_pkg::FLD_W;
  localparam int PW    = sltb_pkg::POS_W;

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_APPLY} state_t;

  state_t                       state_r, state_nxt;
  logic [sltb_pkg::OP_W-1:0]    op_r, op_nxt;
  logic [DATA_WIDTH-1:0]        key_r, key_nxt;
  logic [PW-1:0]                pos_r, pos_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [CNT_W-1:0]             rem_r, rem_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [sltb_pkg::ST_W-1:0]    st_r, st_nxt;
  logic [FW-1:0]                rd_r, rd_nxt;
  logic [CNT_W-1:0]             orem_r, orem_nxt;
  logic [CNT_W-1:0]             ocnt_r, ocnt_nxt;

  sltb_pkg::ctl_t               ctl;
  logic [DATA_WIDTH-1:0]        in_key;
  logic [DATA_WIDTH-1:0]        cell_val [CAPACITY];
  sltb_pkg::flags_t             cell_flags [CAPACITY];
  logic [CAPACITY-1:0]          cell_ins;
  logic                         found;
  logic [DATA_WIDTH-1:0]        rd_sel;
  logic [FW-1:0]                rd_ext;
  logic                         in_acc;
  logic                         stall;
  logic                         full;

  // Key and read value conversion between the 32-bit field and cell width.
  generate
    if (DATA_WIDTH <= FW) begin : g_narrow
      assign in_key = in_tdata[DATA_WIDTH-1:0];
    end else begin : g_wide_in
      assign in_key = {{(DATA_WIDTH - FW){1'b0}}, in_tdata[FW-1:0]};
    end
    if (DATA_WIDTH >= FW) begin : g_rd_trunc
      assign rd_ext = rd_sel[FW-1:0];
    end else begin : g_rd_sext
      assign rd_ext = {{(FW - DATA_WIDTH){rd_sel[DATA_WIDTH-1]}}, rd_sel};
    end
  endgenerate

  generate
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] lv;
      logic [DATA_WIDTH-1:0] rv;
      logic                  li;
      if (g == 0) begin : g_first
        assign lv = cell_val[g];
        assign li = 1'b0;
      end else begin : g_mid_l
        assign lv = cell_val[g-1];
        assign li = cell_ins[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign rv = cell_val[g];
      end else begin : g_mid_r
        assign rv = cell_val[g+1];
      end
      sltb_cell #(
        .DATA_WIDTH (DATA_WIDTH),
        .INDEX      (g),
        .CNT_W      (CNT_W)
      ) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .key       (key_r),
        .count     (count_r),
        .pos       (pos_r),
        .left_val  (lv),
        .right_val (rv),
        .left_ins  (li),
        .value     (cell_val[g]),
        .flags     (cell_flags[g]),
        .ins       (cell_ins[g])
      );
    end
  endgenerate

  // Reduce the captured flags: any match, and the selected read value.
  always_comb begin
    found  = 1'b0;
    rd_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      found  = found | cell_flags[i].eq;
      rd_sel = rd_sel | (cell_flags[i].sel ? cell_val[i] : '0);
    end
  end

  // Any cell at the read position, valid entries only.
  function automatic logic found_sel(input sltb_pkg::flags_t f [CAPACITY]);
    logic any;
    any = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      any = any | f[i].sel;
    end
    return any;
  endfunction

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign stall     = out_valid_r && !out_tready;
  assign full      = (count_r == CNT_W'(CAPACITY));

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_tready;
    st_nxt        = st_r;
    rd_nxt        = rd_r;
    orem_nxt      = orem_r;
    ocnt_nxt      = ocnt_r;
    ctl           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_tuser;
          key_nxt   = in_key;
          pos_nxt   = in_tdata[FW+PW-1:FW];
          rem_nxt   = '0;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        ctl.cmp   = 1'b1;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (!stall) begin
          // Defaults for a finishing step; delete-all may loop instead.
          st_nxt        = sltb_pkg::ST_NOT_FOUND;
          rd_nxt        = '0;
          orem_nxt      = '0;
          ocnt_nxt      = count_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          unique case (op_r)
            sltb_pkg::OP_INSERT: begin
              if (full) begin
                st_nxt = sltb_pkg::ST_FULL;
              end else begin
                ctl.ins   = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                ocnt_nxt  = count_nxt;
                st_nxt    = sltb_pkg::ST_DONE;
              end
            end
            sltb_pkg::OP_FIND: begin
              if (found) begin
                st_nxt = sltb_pkg::ST_DONE;
              end
            end
            sltb_pkg::OP_READ: begin
              if (found_sel(cell_flags)) begin
                st_nxt = sltb_pkg::ST_DONE;
                rd_nxt = rd_ext;
              end
            end
            sltb_pkg::OP_DEL_FIRST: begin
              if (found) begin
                ctl.del   = 1'b1;
                count_nxt = count_r - CNT_W'(1);
                ocnt_nxt  = count_nxt;
                orem_nxt  = CNT_W'(1);
                st_nxt    = sltb_pkg::ST_DONE;
              end
            end
            sltb_pkg::OP_DEL_ALL: begin
              if (found) begin
                // Remove one match and compare again; no result yet.
                ctl.del       = 1'b1;
                count_nxt     = count_r - CNT_W'(1);
                rem_nxt       = rem_r + CNT_W'(1);
                out_valid_nxt = out_valid_r && !out_tready;
                st_nxt        = st_r;
                rd_nxt        = rd_r;
                orem_nxt      = orem_r;
                ocnt_nxt      = ocnt_r;
                state_nxt     = S_CMP;
              end else begin
                orem_nxt = rem_r;
                st_nxt   = (rem_r != '0) ? sltb_pkg::ST_DONE : sltb_pkg::ST_NOT_FOUND;
              end
            end
            default: begin
              st_nxt = sltb_pkg::ST_NOT_FOUND;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r   <= op_nxt;
    key_r  <= key_nxt;
    pos_r  <= pos_nxt;
    st_r   <= st_nxt;
    rd_r   <= rd_nxt;
    orem_r <= orem_nxt;
    ocnt_r <= ocnt_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = st_r;
  assign out_tdata  = {2'b00, PW'(ocnt_r), PW'(orem_r), rd_r};

  `CHK_ASSERT(a_count_cap, clk, rst_n, count_r <= CNT_W'(CAPACITY), "entry count above capacity")
  `CHK_IMPLY(a_out_from_apply, clk, rst_n, $rose(out_valid_r), $past(state_r == S_APPLY), "result raised outside apply step")
  `CHK_IMPLY(a_count_in_apply, clk, rst_n, !$stable(count_r), $past(state_r == S_APPLY), "entry count changed outside apply step")

endmodule

@@ sv/sltb_cell.sv @@
// One cell of the sorted chain: a stored value plus its compare flags.
// Depends on sltb_pkg; instantiated by sorted_list_table_top.
module sltb_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int INDEX      = 0,
  parameter int CNT_W      = 7
) (
  input  logic                         clk,
  input  sltb_pkg::ctl_t               ctl,
  input  logic [DATA_WIDTH-1:0]        key,
  input  logic [CNT_W-1:0]             count,
  input  logic [sltb_pkg::POS_W-1:0]   pos,
  input  logic [DATA_WIDTH-1:0]        left_val,
  input  logic [DATA_WIDTH-1:0]        right_val,
  input  logic                         left_ins,
  output logic [DATA_WIDTH-1:0]        value,
  output sltb_pkg::flags_t             flags,
  output logic                         ins
);

  logic [DATA_WIDTH-1:0] value_r;
  sltb_pkg::flags_t      flags_r;
  sltb_pkg::flags_t      flags_nxt;
  logic                  shl;

  always_comb begin
    flags_nxt.valid = (INDEX < int'(count));
    flags_nxt.gt    = flags_nxt.valid && ($signed(value_r) > $signed(key));
    flags_nxt.eq    = flags_nxt.valid && (value_r == key);
    flags_nxt.sel   = flags_nxt.valid && (int'(pos) == INDEX + 1);
  end

  // Insert region: every cell at or past the first greater entry.
  assign ins = !flags_r.valid || flags_r.gt;
  // Close-up region: every cell from the first match onward.
  assign shl = !flags_r.valid || flags_r.gt || flags_r.eq;

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      flags_r <= flags_nxt;
    end
    if (ctl.ins && ins) begin
      value_r <= left_ins ? left_val : key;
    end else if (ctl.del && shl) begin
      value_r <= right_val;
    end
  end

  assign value = value_r;
  assign flags = flags_r;

endmodule

@@ tb/sv/sorted_list_table_top_test.sv @@
// Self-checking bench for sorted_list_table_top: a queue-fed command driver, a result
// monitor and an in-bench sorted-list predictor. Depends on sltb_pkg and the block's RTL.
module sorted_list_table_top_test;

  localparam int LIST_CAP     = 64;
  localparam int RANDOM_CMDS  = 1600;
  localparam int TAIL_CMDS    = 200;
  localparam int STALL_LIMIT  = 4000;
  localparam int SETTLE_CYCLES = 150;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
    logic [6:0]         pos;
    logic               drain_first;  // wait for every reply before presenting
  } list_cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [6:0]         removed;
    logic [6:0]         count;
  } list_reply_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic [2:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;

  sorted_list_table_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Predictor state: the sorted entries and how many are held.
  logic signed [31:0] list_vals[LIST_CAP];
  int                 list_len = 0;

  list_cmd_t   pending[$];
  list_reply_t predicted_replies[$];
  int          cmds_accepted   = 0;
  int          replies_checked = 0;
  int          fails           = 0;
  logic [31:0] value_pool[10];

  bit tail_phase = 1'b0;
  bit calm       = 1'b0;
  int in_gap     = 0;
  int out_stall  = 0;
  int idle_cycles = 0;
  bit just_took;
  bit go;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic list_reply_t apply_to_list(list_cmd_t c);
    list_reply_t r;
    int idx;
    int k;
    int kept;
    int gone;
    r.status     = sltb_pkg::ST_NOT_FOUND;
    r.read_value = '0;
    r.removed    = '0;
    gone         = 0;
    case (c.op)
      sltb_pkg::OP_INSERT: begin
        if (list_len >= LIST_CAP) begin
          r.status = sltb_pkg::ST_FULL;
        end else begin
          // equal values go after the ones already held
          idx = list_len;
          for (k = 0; k < list_len; k++) begin
            if ($signed(list_vals[k]) > $signed(c.value)) begin
              idx = k;
              break;
            end
          end
          for (k = list_len; k > idx; k--) list_vals[k] = list_vals[k-1];
          list_vals[idx] = c.value;
          list_len++;
          r.status = sltb_pkg::ST_DONE;
        end
      end
      sltb_pkg::OP_FIND: begin
        for (k = 0; k < list_len; k++) begin
          if (list_vals[k] == c.value) begin
            r.status = sltb_pkg::ST_DONE;
            break;
          end
        end
      end
      sltb_pkg::OP_READ: begin
        if (c.pos >= 1 && int'(c.pos) <= list_len) begin
          r.read_value = list_vals[int'(c.pos) - 1];
          r.status     = sltb_pkg::ST_DONE;
        end
      end
      sltb_pkg::OP_DEL_FIRST: begin
        for (k = 0; k < list_len; k++) begin
          if (list_vals[k] == c.value) begin
            for (idx = k; idx + 1 < list_len; idx++) list_vals[idx] = list_vals[idx+1];
            list_len--;
            gone     = 1;
            r.status = sltb_pkg::ST_DONE;
            break;
          end
        end
      end
      sltb_pkg::OP_DEL_ALL: begin
        kept = 0;
        for (k = 0; k < list_len; k++) begin
          if (list_vals[k] == c.value) gone++;
          else begin
            list_vals[kept] = list_vals[k];
            kept++;
          end
        end
        list_len = kept;
        r.status = (gone != 0) ? sltb_pkg::ST_DONE : sltb_pkg::ST_NOT_FOUND;
      end
      default: ;
    endcase
    r.removed = 7'(gone);
    r.count   = 7'(list_len);
    return r;
  endfunction

  function automatic void queue_cmd(logic [2:0] op, logic [31:0] value, logic [6:0] pos,
                                    bit drain);
    list_cmd_t c;
    c.op          = op;
    c.value       = value;
    c.pos         = pos;
    c.drain_first = drain;
    pending.push_back(c);
  endfunction

  // Mostly draw from a small pool so that finds and deletes hit and duplicates pile up.
  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return value_pool[$urandom_range(0, 9)];
  endfunction

  // Driver: present the front of the pending queue, predict on accept.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      just_took = in_tvalid && in_tready;
      if (just_took) begin
        predicted_replies.push_back(apply_to_list(pending.pop_front()));
        cmds_accepted <= cmds_accepted + 1;
      end
      tail_phase <= pending.size() < TAIL_CMDS;
      if ($urandom_range(0, 299) == 0) calm <= !calm;
      // hold the item until it is taken
      if (!(in_tvalid && !in_tready)) begin
        if (in_gap > 0) in_gap--;
        else if (!calm && !tail_phase && $urandom_range(0, 5) == 0)
          in_gap = $urandom_range(1, 19);
        go = in_gap == 0 && pending.size() > 0;
        if (go && pending[0].drain_first)
          go = !just_took && cmds_accepted == replies_checked;
        in_tvalid <= go;
        if (go) begin
          in_tdata <= {1'b0, pending[0].pos, pending[0].value};
          in_tuser <= pending[0].op;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest unchecked prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (replies_checked >= cmds_accepted) begin
          $error("result with no command outstanding: status %0d", out_tuser);
          fails++;
        end else begin
          if (out_tuser !== predicted_replies[replies_checked].status) begin
            $error("status mismatch: expected %0d, got %0d",
                   predicted_replies[replies_checked].status, out_tuser);
            fails++;
          end
          if (out_tdata[31:0] !== predicted_replies[replies_checked].read_value) begin
            $error("read_value mismatch: expected %0d, got %0d",
                   predicted_replies[replies_checked].read_value, $signed(out_tdata[31:0]));
            fails++;
          end
          if (out_tdata[38:32] !== predicted_replies[replies_checked].removed) begin
            $error("removed_count mismatch: expected %0d, got %0d",
                   predicted_replies[replies_checked].removed, out_tdata[38:32]);
            fails++;
          end
          if (out_tdata[45:39] !== predicted_replies[replies_checked].count) begin
            $error("entry_count mismatch: expected %0d, got %0d",
                   predicted_replies[replies_checked].count, out_tdata[45:39]);
            fails++;
          end
          replies_checked <= replies_checked + 1;
        end
      end
      if (out_stall > 0) out_stall--;
      else if (!calm && !tail_phase && $urandom_range(0, 6) == 0)
        out_stall = $urandom_range(1, 19);
      out_tready <= out_stall == 0;
    end
  end

  // Watchdog: end the run when neither side moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("sorted_list_table_top_test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int issued;
    int phase_len;
    int ins_pct;
    int k;
    int r;
    logic [2:0] op;
    logic [6:0] pos;
    bit drain;

    value_pool[0] = 32'h7fff_ffff;
    value_pool[1] = 32'h8000_0000;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    value_pool[4] = 32'h0000_0001;
    for (k = 5; k < 10; k++) value_pool[k] = $urandom();

    // Empty table: every lookup and delete misses, unused codes do nothing.
    queue_cmd(sltb_pkg::OP_READ, 32'd0, 7'd0, 1'b0);
    queue_cmd(sltb_pkg::OP_READ, 32'd0, 7'd1, 1'b0);
    queue_cmd(sltb_pkg::OP_FIND, 32'd0, 7'd0, 1'b0);
    queue_cmd(sltb_pkg::OP_DEL_FIRST, 32'd0, 7'd0, 1'b0);
    queue_cmd(sltb_pkg::OP_DEL_ALL, 32'd0, 7'd0, 1'b0);
    queue_cmd(3'd5, 32'h1234_5678, 7'd3, 1'b0);
    queue_cmd(3'd7, 32'h8000_0000, 7'd64, 1'b0);
    // Extremes and duplicates.
    queue_cmd(sltb_pkg::OP_INSERT, 32'h7fff_ffff, 7'd0, 1'b0);
    queue_cmd(sltb_pkg::OP_INSERT, 32'h8000_0000, 7'd0, 1'b0);
    queue_cmd(sltb_pkg::OP_INSERT, 32'd0, 7'd0, 1'b0);
    queue_cmd(sltb_pkg::OP_INSERT, 32'd0, 7'd0, 1'b0);
    queue_cmd(sltb_pkg::OP_INSERT, 32'hffff_ffff, 7'd0, 1'b0);
    queue_cmd(sltb_pkg::OP_INSERT, 32'h8000_0000, 7'd0, 1'b0);
    queue_cmd(sltb_pkg::OP_READ, 32'd0, 7'd1, 1'b0);
    queue_cmd(sltb_pkg::OP_READ, 32'd0, 7'd6, 1'b0);
    queue_cmd(sltb_pkg::OP_READ, 32'd0, 7'd7, 1'b0);
    queue_cmd(sltb_pkg::OP_READ, 32'hffff_ffff, 7'd127, 1'b0);
    queue_cmd(sltb_pkg::OP_FIND, 32'h7fff_ffff, 7'd0, 1'b0);
    queue_cmd(sltb_pkg::OP_FIND, 32'd5, 7'd0, 1'b0);
    queue_cmd(sltb_pkg::OP_DEL_FIRST, 32'd0, 7'd0, 1'b0);
    queue_cmd(sltb_pkg::OP_DEL_ALL, 32'h8000_0000, 7'd0, 1'b0);
    queue_cmd(sltb_pkg::OP_DEL_ALL, 32'h0001_2345, 7'd0, 1'b0);
    queue_cmd(3'd6, 32'hffff_ffff, 7'd127, 1'b0);
    queue_cmd(sltb_pkg::OP_READ, 32'd0, 7'd2, 1'b0);

    // Random phases: grow toward full, churn, or shrink.
    issued = 0;
    drain  = 1'b1;
    while (issued < RANDOM_CMDS) begin
      phase_len = $urandom_range(60, 200);
      case ($urandom_range(0, 2))
        0:       ins_pct = 70;
        1:       ins_pct = 35;
        default: ins_pct = 15;
      endcase
      for (k = 0; k < phase_len && issued < RANDOM_CMDS; k++) begin
        if ($urandom_range(0, 99) < ins_pct) begin
          op = sltb_pkg::OP_INSERT;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 25)      op = sltb_pkg::OP_FIND;
          else if (r < 55) op = sltb_pkg::OP_READ;
          else if (r < 80) op = sltb_pkg::OP_DEL_FIRST;
          else if (r < 95) op = sltb_pkg::OP_DEL_ALL;
          else             op = 3'($urandom_range(5, 7));
        end
        pos = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, 66))
                                           : 7'($urandom_range(0, 127));
        queue_cmd(op, pick_value(), pos, drain);
        drain = 1'b0;
        issued++;
      end
      drain = $urandom_range(0, 2) == 0;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Sample between edges so that the bookkeeping of the last edge has settled.
    while (pending.size() != 0 || replies_checked != cmds_accepted) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("sorted_list_table_top_test passed");
    end else begin
      $display("sorted_list_table_top_test failed");
    end
    $finish;
  end

endmodule
